// ===== hdl/srpu_pkg.sv =====
// Shared types, constants and helpers for the sparse row pattern union block.
`default_nettype none
package srpu_pkg;

   localparam int MaxColumns = 64;
   localparam int ColW       = 6;
   localparam int LimitW     = 7;
   localparam int CountW     = 24;
   localparam int QDepth     = 4;
   localparam int QPtrW      = $clog2(QDepth);
   localparam int QCntW      = $clog2(QDepth + 1);

   localparam logic [CountW-1:0] CountMax      = {CountW{1'b1}};
   localparam logic [LimitW-1:0] ColumnsReset  = LimitW'(64);
   localparam logic [LimitW-1:0] ColumnsCap    = LimitW'(MaxColumns);

   typedef struct packed {
      logic [ColW-1:0] col;
      logic            mark;
      logic            drop;
      logic            row_end;
   } srpu_item_type;

   typedef enum logic [0:0] {
      SRPU_IDLE,
      SRPU_EMIT
   } srpu_state_type;

   function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
      return (v == CountMax) ? v : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sparse_row_pattern_union.sv =====
// A row-end word is written into the queue, popped in the idle state, and then scanned into the result register.
// Throughput: one marking word per cycle into the queue while it is not full; a row end then
// starts the bitmap scan: one result per marked column, per cycle while rsp_stall is low.
// A four-word queue between front and back lets input keep flowing during that scan until it fills.
// Reset: synchronous, active high; clears bitmap, counters, drop flag and queue;
// the column limit register returns to 64.
`default_nettype none
module sparse_row_pattern_union
   import srpu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [LimitW-1:0] csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ColW-1:0]   req_column_index,
   input  wire logic              req_column_present,
   input  wire logic              req_row_end,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [ColW-1:0]        rsp_union_column,
   output logic                   rsp_entry_valid,
   output logic                   rsp_last_of_row,
   output logic [CountW-1:0]      rsp_nonzero_total,
   output logic [CountW-1:0]      rsp_row_number,
   output logic                   rsp_index_dropped
);

   logic          q_valid, q_pop;
   srpu_item_type q_item;

   srpu_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_column_index   (req_column_index),
      .req_column_present (req_column_present),
      .req_row_end        (req_row_end),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   srpu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_union_column  (rsp_union_column),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_last_of_row   (rsp_last_of_row),
      .rsp_nonzero_total (rsp_nonzero_total),
      .rsp_row_number    (rsp_row_number),
      .rsp_index_dropped (rsp_index_dropped)
   );

endmodule
`default_nettype wire

// ===== hdl/srpu_front.sv =====
// Front part: column limit register, word classification and the item queue.
`default_nettype none
module srpu_front
   import srpu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [LimitW-1:0] csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ColW-1:0]   req_column_index,
   input  wire logic              req_column_present,
   input  wire logic              req_row_end,
   output logic                   q_valid,
   output srpu_item_type          q_item,
   input  wire logic              q_pop
);

   logic [LimitW-1:0] columns_ff, columns_in;
   logic [QPtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]  count_ff, count_in;
   srpu_item_type     queue_ff [QDepth];
   srpu_item_type     item;
   logic [LimitW-1:0] limit;
   logic              in_range;
   logic              accept;

   assign limit    = (columns_ff > ColumnsCap) ? ColumnsCap : columns_ff;
   assign in_range = {1'b0, req_column_index} < limit;

   always_comb begin
      item.col     = req_column_index;
      item.mark    = req_column_present & in_range;
      item.drop    = req_column_present & ~in_range;
      item.row_end = req_row_end;
   end

   assign req_stall = (count_ff == QCntW'(QDepth));
   assign accept    = req_valid & ~req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   assign columns_in = csr_write_enable ? csr_write_data : columns_ff;
   assign wr_ptr_in  = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in  = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in   = count_ff + QCntW'(accept) - QCntW'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= ColumnsReset;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         columns_ff <= columns_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCntW'(QDepth)) && !q_pop |=> count_ff == QCntW'(QDepth))
      else $error("full queue changed level without a pop");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !q_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue level did not rise on write");

endmodule
`default_nettype wire

// ===== hdl/srpu_back.sv =====
// Back part: column bitmap, ascending scan, counters and the result register.
`default_nettype none
module srpu_back
   import srpu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire srpu_item_type     q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [ColW-1:0]        rsp_union_column,
   output logic                   rsp_entry_valid,
   output logic                   rsp_last_of_row,
   output logic [CountW-1:0]      rsp_nonzero_total,
   output logic [CountW-1:0]      rsp_row_number,
   output logic                   rsp_index_dropped
);

   srpu_state_type         state_ff, state_in;
   logic [MaxColumns-1:0]  marks_ff, marks_in;
   logic [CountW-1:0]      entries_ff, entries_in, rows_ff, rows_in;
   logic                   dropped_ff, dropped_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ColW-1:0]        rsp_col_ff, rsp_col_in;
   logic                   rsp_entry_ff, rsp_entry_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [CountW-1:0]      rsp_total_ff, rsp_total_in;
   logic [CountW-1:0]      rsp_row_ff, rsp_row_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   logic                   out_free, emit, marks_empty, last;
   logic [MaxColumns-1:0]  set_mask, remaining;
   logic [ColW-1:0]        low_idx;

   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign marks_empty = (marks_ff == '0);
   assign remaining   = marks_ff & (marks_ff - 1'b1);
   assign last        = marks_empty | (remaining == '0);

   always_comb begin
      low_idx = '0;
      for (int i = MaxColumns - 1; i >= 0; i--) begin
         if (marks_ff[i]) low_idx = ColW'(i);
      end
   end

   always_comb begin
      set_mask = '0;
      for (int i = 0; i < MaxColumns; i++) begin
         set_mask[i] = q_item.mark & (q_item.col == ColW'(i));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SRPU_IDLE: begin
            if (q_valid && q_item.row_end) state_in = SRPU_EMIT;
         end
         SRPU_EMIT: begin
            if (out_free && last) state_in = SRPU_IDLE;
         end
         default: state_in = SRPU_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop = 1'b0;
      emit  = 1'b0;
      case (state_ff)
         SRPU_IDLE: q_pop = q_valid;
         SRPU_EMIT: emit  = out_free;
         default: begin
            q_pop = 1'b0;
            emit  = 1'b0;
         end
      endcase
   end

   always_comb begin
      marks_in     = marks_ff;
      entries_in   = entries_ff;
      rows_in      = rows_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_total_in = rsp_total_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_drop_in  = rsp_drop_ff;
      if (q_pop) begin
         marks_in   = marks_ff | set_mask;
         dropped_in = dropped_ff | q_item.drop;
      end
      if (emit) begin
         rsp_row_in  = rows_ff;
         rsp_drop_in = dropped_ff;
         rsp_last_in = last;
         if (last) rows_in = sat_inc(rows_ff);
         if (marks_empty) begin
            rsp_col_in   = '0;
            rsp_entry_in = 1'b0;
            rsp_total_in = entries_ff;
         end else begin
            marks_in     = remaining;
            entries_in   = sat_inc(entries_ff);
            rsp_col_in   = low_idx;
            rsp_entry_in = 1'b1;
            rsp_total_in = sat_inc(entries_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SRPU_IDLE;
         marks_ff     <= '0;
         entries_ff   <= '0;
         rows_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         marks_ff     <= marks_in;
         entries_ff   <= entries_in;
         rows_ff      <= rows_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff   <= rsp_col_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_union_column  = rsp_col_ff;
   assign rsp_entry_valid   = rsp_entry_ff;
   assign rsp_last_of_row   = rsp_last_ff;
   assign rsp_nonzero_total = rsp_total_ff;
   assign rsp_row_number    = rsp_row_ff;
   assign rsp_index_dropped = rsp_drop_ff;

   a_row_close: assert property (@(posedge clock) disable iff (reset)
      emit && last |=> state_ff == SRPU_IDLE && marks_ff == '0)
      else $error("row closed with marks left");

   a_one_bit_per_word: assert property (@(posedge clock) disable iff (reset)
      emit && !marks_empty |=>
         $countones(marks_ff) == $countones($past(marks_ff)) - 1)
      else $error("scan did not clear exactly one mark");

   a_marker_only_empty: assert property (@(posedge clock) disable iff (reset)
      emit && marks_empty |=> rsp_valid_ff && !rsp_entry_ff && rsp_last_ff)
      else $error("empty row marker malformed");

   a_no_pop_in_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == SRPU_EMIT |-> !q_pop && dropped_in == dropped_ff)
      else $error("queue popped while emitting");

endmodule
`default_nettype wire
